// ----- rtl/core/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DEPTH_DEF     = 4096;
  localparam int MAX_BLOCK_DEF = 64;

  localparam int ACT_W   = 3;
  localparam int DATA_W  = 8;
  localparam int LEN_W   = 7;
  localparam int COUNT_W = 12;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ     = 3'd0,
    ACT_DEQ     = 3'd1,
    ACT_PEEK    = 3'd2,
    ACT_DISCARD = 3'd3,
    ACT_CLEAR   = 3'd4
  } brb_action_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } brb_state_t;

endpackage

// ----- rtl/core/brb_store.sv -----
// ----------------------------------------------------------------------------
// brb_store
// Byte store of the ring buffer: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module brb_store
  import brb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int PW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [PW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [PW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/byte_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Byte circular FIFO with block enqueue, block dequeue and peek, discard and
// clear.
// ----------------------------------------------------------------------------
// Holds up to DEPTH-1 bytes in a single-port-write, single-port-read store.
// Enqueue, discard, clear and every rejected request give one result each; a new
// request is taken every cycle while the result register drains. A dequeue or
// peek of n bytes reads the store one byte per cycle while the output is not
// stalled, and the input stalls until the last byte has moved to the result
// register and the sequencer returns to idle. Used and free counts on every
// result are the values after the whole request, reported modulo 4096.
module byte_ring_buffer
  import brb_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [DATA_W-1:0]  in_data_in,
  input  logic [LEN_W-1:0]   in_block_length,
  input  logic               in_first_of_block,
  input  logic [COUNT_W-1:0] in_discard_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  out_data_out,
  output logic               out_ok,
  output logic               out_last,
  output logic [COUNT_W-1:0] out_used_count,
  output logic [COUNT_W-1:0] out_free_count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = (PW > COUNT_W) ? PW : COUNT_W;
  localparam int SW = CW + 1;
  localparam logic [SW-1:0]    DEPTH_S  = SW'(DEPTH);
  localparam logic [PW-1:0]    PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0]    CAP      = CW'(DEPTH - 1);
  localparam logic [LEN_W-1:0] MAXB     = LEN_W'(MAX_BLOCK);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  brb_state_t         state_r, state_nxt;
  logic [PW-1:0]      rp_r, rp_nxt;
  logic [PW-1:0]      wp_r, wp_nxt;
  logic [PW-1:0]      used_r, used_nxt;
  logic [LEN_W-1:0]   bbl_r, bbl_nxt;
  logic               rej_r, rej_nxt;
  logic [PW-1:0]      rd_addr_r, rd_addr_nxt;
  logic [LEN_W-1:0]   rd_left_r, rd_left_nxt;
  logic               b_valid_r, b_valid_nxt;
  logic               b_last_r, b_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_data_r;
  logic               out_ok_r;
  logic               out_last_r;
  logic [COUNT_W-1:0] out_used_r;
  logic [COUNT_W-1:0] out_free_r;

  logic               accept;
  logic               wr_en;
  logic               rd_en;
  logic               single_load;
  logic               s_ok;
  logic               out_load_b;
  logic [CW-1:0]      used_c;
  logic [CW-1:0]      free_c;
  logic [CW-1:0]      len_c;
  logic [CW-1:0]      dcnt_c;
  logic [SW-1:0]      adv_sum;
  logic [PW-1:0]      rp_adv;
  logic [CW-1:0]      cnt_used;
  logic [CW-1:0]      cnt_free;
  logic [DATA_W-1:0]  rd_data;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);

  assign used_c = CW'(used_r);
  assign free_c = CAP - used_c;
  assign len_c  = CW'(in_block_length);
  assign dcnt_c = CW'(in_discard_count);

  // one adder for both read pointer moves, the amount applied never exceeds used
  assign adv_sum = SW'(rp_r) +
                   ((in_action == ACT_DISCARD) ? SW'(in_discard_count) : SW'(in_block_length));
  assign rp_adv  = (adv_sum >= DEPTH_S) ? PW'(adv_sum - DEPTH_S) : PW'(adv_sum);

  assign out_load_b = b_valid_r && (!out_valid_r || !out_stall);
  assign rd_en      = (state_r == ST_READ) && (rd_left_r != '0) && (!b_valid_r || out_load_b);

  always_comb begin
    state_nxt   = state_r;
    rp_nxt      = rp_r;
    wp_nxt      = wp_r;
    used_nxt    = used_r;
    bbl_nxt     = bbl_r;
    rej_nxt     = rej_r;
    rd_addr_nxt = rd_addr_r;
    rd_left_nxt = rd_left_r;
    wr_en       = 1'b0;
    single_load = 1'b0;
    s_ok        = 1'b0;

    if (accept) begin
      single_load = 1'b1;
      case (in_action)
        ACT_ENQ: begin
          if (in_first_of_block) begin
            bbl_nxt = '0;
            rej_nxt = 1'b0;
            if (in_block_length == '0) begin
              s_ok = (free_c != '0);
            end else if (in_block_length > MAXB || len_c > free_c) begin
              bbl_nxt = in_block_length - LEN_W'(1);
              rej_nxt = 1'b1;
            end else begin
              wr_en   = 1'b1;
              bbl_nxt = in_block_length - LEN_W'(1);
              s_ok    = 1'b1;
            end
          end else if (bbl_r != '0) begin
            bbl_nxt = bbl_r - LEN_W'(1);
            if (!rej_r && free_c != '0) begin
              wr_en = 1'b1;
              s_ok  = 1'b1;
            end
          end
          if (wr_en) begin
            wp_nxt   = ptr_inc(wp_r);
            used_nxt = used_r + PW'(1);
          end
        end
        ACT_DEQ, ACT_PEEK: begin
          if (in_block_length > MAXB || used_r == '0 || len_c > used_c) begin
            s_ok = 1'b0;
          end else if (in_block_length == '0) begin
            s_ok = 1'b1;
          end else begin
            single_load = 1'b0;
            state_nxt   = ST_READ;
            rd_addr_nxt = rp_r;
            rd_left_nxt = in_block_length;
            if (in_action == ACT_DEQ) begin
              rp_nxt   = rp_adv;
              used_nxt = used_r - PW'(in_block_length);
            end
          end
        end
        ACT_DISCARD: begin
          if (dcnt_c <= used_c) begin
            rp_nxt   = rp_adv;
            used_nxt = used_r - PW'(in_discard_count);
            s_ok     = 1'b1;
          end
        end
        ACT_CLEAR: begin
          rp_nxt   = '0;
          wp_nxt   = '0;
          used_nxt = '0;
          bbl_nxt  = '0;
          rej_nxt  = 1'b0;
          s_ok     = 1'b1;
        end
        default: begin
          s_ok = 1'b0;
        end
      endcase
    end

    // byte read sequencer
    if (rd_en) begin
      rd_addr_nxt = ptr_inc(rd_addr_r);
      rd_left_nxt = rd_left_r - LEN_W'(1);
    end
    if (state_r == ST_READ && rd_left_r == '0 && !b_valid_r) begin
      state_nxt = ST_IDLE;
    end
  end

  assign b_valid_nxt = rd_en || (b_valid_r && !out_load_b);
  assign b_last_nxt  = rd_en ? (rd_left_r == LEN_W'(1)) : b_last_r;

  always_comb begin
    if (single_load || out_load_b) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // counts after the request: used_r is already final while bytes stream out
  assign cnt_used = single_load ? CW'(used_nxt) : used_c;
  assign cnt_free = CAP - cnt_used;

  brb_store #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (in_data_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      used_r      <= '0;
      bbl_r       <= '0;
      rej_r       <= 1'b0;
      rd_left_r   <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      used_r      <= used_nxt;
      bbl_r       <= bbl_nxt;
      rej_r       <= rej_nxt;
      rd_left_r   <= rd_left_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    b_last_r  <= b_last_nxt;
    if (single_load) begin
      out_data_r <= '0;
      out_ok_r   <= s_ok;
      out_last_r <= 1'b1;
      out_used_r <= cnt_used[COUNT_W-1:0];
      out_free_r <= cnt_free[COUNT_W-1:0];
    end else if (out_load_b) begin
      out_data_r <= rd_data;
      out_ok_r   <= 1'b1;
      out_last_r <= b_last_r;
      out_used_r <= cnt_used[COUNT_W-1:0];
      out_free_r <= cnt_free[COUNT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_ok         = out_ok_r;
  assign out_last       = out_last_r;
  assign out_used_count = out_used_r;
  assign out_free_count = out_free_r;

endmodule

// ----- tb/byte_ring_buffer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_checker
// Watches both channels of the byte ring buffer, predicts the results of each
// accepted request from its own copy of the ring, and compares every result
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module byte_ring_buffer_checker
  import brb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [DATA_W-1:0]  in_data_in,
  input  logic [LEN_W-1:0]   in_block_length,
  input  logic               in_first_of_block,
  input  logic [COUNT_W-1:0] in_discard_count,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [DATA_W-1:0]  out_data_out,
  input  logic               out_ok,
  input  logic               out_last,
  input  logic [COUNT_W-1:0] out_used_count,
  input  logic [COUNT_W-1:0] out_free_count,
  output int                 mismatches,
  output int                 pending,
  output int                 checked
);

  localparam int RING    = DEPTH_DEF;
  localparam int MAX_LEN = MAX_BLOCK_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic               ok;
    logic               last;
    logic [COUNT_W-1:0] used;
    logic [COUNT_W-1:0] free;
  } ring_result_t;

  ring_result_t      expected_results[$];
  logic [DATA_W-1:0] ring_mem [RING];
  int                rd_ptr;
  int                wr_ptr;
  int                blk_left;
  logic              blk_rejected;
  int                bad_count = 0;
  int                seen_count = 0;

  function automatic int used_bytes();
    return (wr_ptr - rd_ptr + RING) % RING;
  endfunction

  function automatic int free_bytes();
    return RING - 1 - used_bytes();
  endfunction

  function automatic void store_byte(logic [DATA_W-1:0] d);
    ring_mem[wr_ptr] = d;
    wr_ptr = (wr_ptr + 1) % RING;
  endfunction

  // counts are taken after the whole request, so call once the state is final
  function automatic void push_result(logic [DATA_W-1:0] d, logic ok, logic last);
    ring_result_t r;
    r.data = d;
    r.ok   = ok;
    r.last = last;
    r.used = COUNT_W'(used_bytes());
    r.free = COUNT_W'(free_bytes());
    expected_results.push_back(r);
  endfunction

  function automatic void predict_request(logic [ACT_W-1:0] act, logic [DATA_W-1:0] d,
                                          logic [LEN_W-1:0] len, logic first,
                                          logic [COUNT_W-1:0] dcount);
    int   start;
    int   n_bytes;
    int   stored;
    logic ok;
    start   = rd_ptr;
    n_bytes = 0;
    ok      = 1'b0;
    case (act)
      ACT_ENQ: begin
        if (first) begin
          blk_left     = 0;
          blk_rejected = 1'b0;
          if (len == 0) begin
            ok = (free_bytes() > 0);
          end else if (len > MAX_LEN || len > free_bytes()) begin
            // whole block dropped, but its remaining bytes are still swallowed
            blk_left     = len - 1;
            blk_rejected = 1'b1;
          end else begin
            store_byte(d);
            blk_left = len - 1;
            ok       = 1'b1;
          end
        end else if (blk_left != 0) begin
          blk_left--;
          if (!blk_rejected && free_bytes() > 0) begin
            store_byte(d);
            ok = 1'b1;
          end
        end
      end
      ACT_DEQ, ACT_PEEK: begin
        stored = used_bytes();
        if (len > MAX_LEN || stored == 0 || len > stored) begin
          ok = 1'b0;
        end else if (len == 0) begin
          ok = 1'b1;
        end else begin
          n_bytes = len;
          if (act == ACT_DEQ) begin
            rd_ptr = (rd_ptr + n_bytes) % RING;
          end
        end
      end
      ACT_DISCARD: begin
        if (dcount <= used_bytes()) begin
          rd_ptr = (rd_ptr + dcount) % RING;
          ok     = 1'b1;
        end
      end
      ACT_CLEAR: begin
        rd_ptr       = 0;
        wr_ptr       = 0;
        blk_left     = 0;
        blk_rejected = 1'b0;
        ok           = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    if (n_bytes == 0) begin
      push_result('0, ok, 1'b1);
    end else begin
      for (int k = 0; k < n_bytes; k++) begin
        push_result(ring_mem[(start + k) % RING], 1'b1, k == n_bytes - 1);
      end
    end
  endfunction

  always @(posedge clk) begin : watch_channels
    ring_result_t got;
    ring_result_t want;
    if (!rst_n) begin
      rd_ptr       = 0;
      wr_ptr       = 0;
      blk_left     = 0;
      blk_rejected = 1'b0;
      expected_results.delete();
    end else begin
      // a result can never belong to a request taken at this same edge
      if (out_valid && !out_stall) begin
        got.data = out_data_out;
        got.ok   = out_ok;
        got.last = out_last;
        got.used = out_used_count;
        got.free = out_free_count;
        if (expected_results.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_LIMIT) begin
            $display("[%0t] result with nothing expected: data %h ok %b last %b used %0d free %0d",
                     $time, got.data, got.ok, got.last, got.used, got.free);
          end
        end else begin
          want = expected_results.pop_front();
          seen_count++;
          if (got !== want) begin
            bad_count++;
            if (bad_count <= REPORT_LIMIT) begin
              $display("[%0t] result %0d mismatch:", $time, seen_count);
              $display("  expected data %h ok %b last %b used %0d free %0d",
                       want.data, want.ok, want.last, want.used, want.free);
              $display("  actual   data %h ok %b last %b used %0d free %0d",
                       got.data, got.ok, got.last, got.used, got.free);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_request(in_action, in_data_in, in_block_length, in_first_of_block,
                        in_discard_count);
      end
    end
    mismatches <= bad_count;
    checked    <= seen_count;
    pending    <= expected_results.size();
  end

endmodule

// ----- tb/byte_ring_buffer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_tb
// Drives the byte ring buffer with directed corner requests, a long output
// stall, a block of the largest length read back whole, and random block
// traffic with random gaps on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module byte_ring_buffer_tb;
  import brb_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_GAP      = 14;
  localparam int TARGET_ITEMS = 40;
  localparam int LEN_TOP      = (1 << LEN_W) - 1;
  localparam logic [ACT_W-1:0] ACT_LAST = '1;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [ACT_W-1:0]   in_action;
  logic [DATA_W-1:0]  in_data_in;
  logic [LEN_W-1:0]   in_block_length;
  logic               in_first_of_block;
  logic [COUNT_W-1:0] in_discard_count;
  logic               out_valid;
  logic               out_stall;
  logic [DATA_W-1:0]  out_data_out;
  logic               out_ok;
  logic               out_last;
  logic [COUNT_W-1:0] out_used_count;
  logic [COUNT_W-1:0] out_free_count;

  int   mismatches;
  int   pending;
  int   checked;
  logic no_idle       = 1'b0;
  int   hold_ask      = 0;
  int   holds_served  = 0;
  int   requests_sent = 0;
  int   idle_cycles   = 0;

  byte_ring_buffer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_data_in        (in_data_in),
    .in_block_length   (in_block_length),
    .in_first_of_block (in_first_of_block),
    .in_discard_count  (in_discard_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_out      (out_data_out),
    .out_ok            (out_ok),
    .out_last          (out_last),
    .out_used_count    (out_used_count),
    .out_free_count    (out_free_count)
  );

  byte_ring_buffer_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_data_in        (in_data_in),
    .in_block_length   (in_block_length),
    .in_first_of_block (in_first_of_block),
    .in_discard_count  (in_discard_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_out      (out_data_out),
    .out_ok            (out_ok),
    .out_last          (out_last),
    .out_used_count    (out_used_count),
    .out_free_count    (out_free_count),
    .mismatches        (mismatches),
    .pending           (pending),
    .checked           (checked)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // one request: offered at a falling edge, held until taken
  task automatic send_req(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] d,
                          input logic [LEN_W-1:0] len, input logic first,
                          input logic [COUNT_W-1:0] dcount);
    int gap;
    in_action         = act;
    in_data_in        = d;
    in_block_length   = len;
    in_first_of_block = first;
    in_discard_count  = dcount;
    in_valid          = 1'b1;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    @(negedge clk);
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic enq_block(input int len, input int n_bytes);
    send_req(ACT_ENQ, DATA_W'($urandom()), LEN_W'(len), 1'b1, COUNT_W'($urandom()));
    for (int i = 1; i < n_bytes; i++) begin
      send_req(ACT_ENQ, DATA_W'($urandom()), LEN_W'($urandom()), 1'b0,
               COUNT_W'($urandom()));
    end
  endtask

  task automatic read_req(input logic [ACT_W-1:0] act, input int len);
    send_req(act, DATA_W'($urandom()), LEN_W'(len), 1'($urandom()), COUNT_W'($urandom()));
  endtask

  task automatic discard_req(input int cnt);
    send_req(ACT_DISCARD, DATA_W'($urandom()), LEN_W'($urandom()), 1'($urandom()),
             COUNT_W'(cnt));
  endtask

  // receiver side: random stall per result, plus one long hold-off on request
  initial begin
    int wait_cycles;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_ask != holds_served) begin
        holds_served++;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (wait_cycles != 0) begin
          out_stall = 1'b1;
          repeat (wait_cycles) @(negedge clk);
        end
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending);
      $display("byte_ring_buffer_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    int n_bytes;
    int pick;
    int good_items;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_action         = ACT_ENQ;
    in_data_in        = '0;
    in_block_length   = '0;
    in_first_of_block = 1'b0;
    in_discard_count  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // corner cases on an empty ring
    send_req(ACT_ENQ, 8'h00, '0, 1'b1, '0);   // zero length block
    send_req(ACT_ENQ, 8'hFF, 7'd5, 1'b0, '1);  // stray byte, no open block
    read_req(ACT_DEQ, 0);
    discard_req(1);
    send_req(ACT_ENQ, 8'h00, 7'd3, 1'b1, '1);
    send_req(ACT_ENQ, 8'hFF, '0, 1'b0, '0);
    send_req(ACT_ENQ, 8'hA5, '1, 1'b0, '1);
    enq_block(MAX_BLOCK_DEF + 1, 2);           // overlong block
    enq_block(LEN_TOP, 2);
    enq_block(4, 2);                           // abandoned by next first byte
    enq_block(2, 2);
    read_req(ACT_PEEK, 0);
    read_req(ACT_PEEK, 3);
    read_req(ACT_DEQ, MAX_BLOCK_DEF + 1);
    read_req(ACT_DEQ, 100);                    // more than stored
    read_req(ACT_DEQ, 2);
    discard_req(DEPTH_DEF - 1);
    discard_req(1);
    for (int a = ACT_CLEAR + 1; a <= ACT_LAST; a++) begin
      send_req(ACT_W'(a), '1, '1, 1'b1, '1);
    end
    send_req(ACT_CLEAR, DATA_W'($urandom()), LEN_W'($urandom()), 1'b1, COUNT_W'($urandom()));
    read_req(ACT_PEEK, 1);

    // long output hold-off while requests keep coming, input must back up
    no_idle = 1'b1;
    hold_ask++;
    enq_block(40, 40);
    repeat (4) read_req(ACT_PEEK, 8);

    // one block of the largest length, read back whole
    send_req(ACT_CLEAR, '0, '0, 1'b0, '0);
    enq_block(MAX_BLOCK_DEF, MAX_BLOCK_DEF);
    read_req(ACT_PEEK, MAX_BLOCK_DEF);
    read_req(ACT_DEQ, MAX_BLOCK_DEF);
    discard_req(1);
    no_idle = 1'b0;

    // random traffic, mostly whole blocks and sensible reads
    good_items = 0;
    while (good_items < TARGET_ITEMS) begin
      if ($urandom_range(0, 24) == 0) begin
        no_idle = ~no_idle;
      end
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        if ($urandom_range(0, 15) == 0) begin
          len     = $urandom_range(MAX_BLOCK_DEF + 1, LEN_TOP);
          n_bytes = $urandom_range(1, 3);
        end else begin
          len     = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_BLOCK_DEF)
                                                : $urandom_range(1, 8);
          n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
        end
        enq_block(len, n_bytes);
        good_items += n_bytes;
      end else if (pick < 15) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, LEN_TOP)
                                          : $urandom_range(0, 12);
        read_req((pick < 13) ? ACT_DEQ : ACT_PEEK, len);
        good_items++;
      end else if (pick < 17) begin
        discard_req(($urandom_range(0, 7) == 0) ? $urandom_range(0, DEPTH_DEF - 1)
                                                : $urandom_range(0, 10));
        good_items++;
      end else if (pick == 17) begin
        send_req(ACT_CLEAR, DATA_W'($urandom()), LEN_W'($urandom()), 1'($urandom()),
                 COUNT_W'($urandom()));
        good_items++;
      end else begin
        case ($urandom_range(0, 2))
          0: send_req(ACT_ENQ, DATA_W'($urandom()), LEN_W'($urandom()), 1'b0,
                      COUNT_W'($urandom()));
          1: send_req(ACT_W'($urandom_range(ACT_CLEAR + 1, ACT_LAST)), DATA_W'($urandom()),
                      LEN_W'($urandom()), 1'($urandom()), COUNT_W'($urandom()));
          default: send_req(ACT_W'($urandom()), DATA_W'($urandom()), LEN_W'($urandom()),
                            1'($urandom()), COUNT_W'($urandom()));
        endcase
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d requests taken, %0d results checked, %0d mismatches",
             requests_sent, checked, mismatches);
    $display("summary: block enqueue and rejects, reads, discards, clears, longest block");
    if (mismatches == 0 && pending == 0) begin
      $display("byte_ring_buffer_tb: clean");
    end else begin
      $display("byte_ring_buffer_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/brb_pkg.sv
rtl/core/brb_store.sv
rtl/core/byte_ring_buffer.sv
tb/byte_ring_buffer_checker.sv
tb/byte_ring_buffer_tb.sv
